[rtl/u8cp_pkg.sv]
package u8cp_pkg;

  // Width of an assembled code point (up to four bytes of UTF-8 payload).
  localparam int POINT_W = 21;

  // Code point reported with every error status.
  localparam logic [31:0] ERR_POINT = 32'hFFFF_FFFF;

  // Depth of the queue between front and back; kept a power of two so the
  // pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Scan mode of the back end.
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LEAD,
    MODE_TARGET,
    MODE_SKIP
  } mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_FOUND  = 3'd0,
    ST_LEAD   = 3'd1,
    ST_CONT   = 3'd2,
    ST_EARLY  = 3'd3,
    ST_BEYOND = 3'd4
  } status_t;

  // Classified byte as it travels from front to back.
  typedef struct packed {
    logic       start;      // first byte of a new string
    logic       is_zero;    // terminator
    logic       is_cont;    // 0x80..0xBF
    logic       bad_lead;   // not usable as a lead byte (nonzero)
    logic [1:0] tail_len;   // continuation bytes that follow a lead
    logic [6:0] lead_bits;  // payload bits carried by a lead byte
    logic [5:0] cont_bits;  // payload bits carried by a continuation byte
  } cls_t;

endpackage

[rtl/u8cp_front.sv]
module u8cp_front #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                   in_valid,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_string_start,
  input  logic [31:0]            in_wanted_index,
  input  logic                   q_full,
  output logic                   in_stall,
  output logic                   q_push,
  output u8cp_pkg::cls_t         q_cls,
  output logic [INDEX_WIDTH-1:0] q_index
);

  // A beat is taken whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_index  = INDEX_WIDTH'(in_wanted_index);

  // Classify the byte by its leading bits.
  always_comb begin
    q_cls           = '0;
    q_cls.start     = in_string_start;
    q_cls.is_zero   = (in_data_byte == 8'h00);
    q_cls.is_cont   = (in_data_byte[7:6] == 2'b10);
    q_cls.bad_lead  = (in_data_byte[7:6] == 2'b10) || (in_data_byte[7:3] == 5'b11111);
    q_cls.cont_bits = in_data_byte[5:0];
    priority if (in_data_byte[7] == 1'b0) begin
      q_cls.tail_len  = 2'd0;
      q_cls.lead_bits = in_data_byte[6:0];
    end else if (in_data_byte[7:5] == 3'b110) begin
      q_cls.tail_len  = 2'd1;
      q_cls.lead_bits = {2'b00, in_data_byte[4:0]};
    end else if (in_data_byte[7:4] == 4'b1110) begin
      q_cls.tail_len  = 2'd2;
      q_cls.lead_bits = {3'b000, in_data_byte[3:0]};
    end else if (in_data_byte[7:3] == 5'b11110) begin
      q_cls.tail_len  = 2'd3;
      q_cls.lead_bits = {4'b0000, in_data_byte[2:0]};
    end else begin
      q_cls.tail_len  = 2'd0;
      q_cls.lead_bits = 7'd0;
    end
  end

endmodule

[rtl/u8cp_queue.sv]
module u8cp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty
);

  logic [WIDTH-1:0]            mem_r [u8cp_pkg::QUEUE_DEPTH];
  logic [u8cp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u8cp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u8cp_pkg::QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (u8cp_pkg::QPTR_W + 1)'(u8cp_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/u8cp_back.sv]
module u8cp_back #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_not_empty,
  input  u8cp_pkg::cls_t         q_cls,
  input  logic [INDEX_WIDTH-1:0] q_index,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_code_point,
  output u8cp_pkg::status_t      out_status
);

  u8cp_pkg::mode_t                mode_r, mode_nxt, mode_eff;
  logic [INDEX_WIDTH-1:0]         count_r, count_nxt, count_eff;
  logic [INDEX_WIDTH-1:0]         target_r, target_nxt, target_eff;
  logic [1:0]                     left_r, left_nxt;
  logic [u8cp_pkg::POINT_W-1:0]   partial_r, partial_nxt, partial_new;
  logic                           out_valid_r, out_valid_nxt;
  logic [31:0]                    out_point_r, out_point_nxt;
  u8cp_pkg::status_t              out_status_r, out_status_nxt;
  logic                           emit;
  logic [31:0]                    emit_point;
  u8cp_pkg::status_t              emit_status;

  // Take a classified byte when the output register is free or being emptied.
  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  assign out_valid      = out_valid_r;
  assign out_code_point = out_point_r;
  assign out_status     = out_status_r;

  assign partial_new = {partial_r[u8cp_pkg::POINT_W-7:0], q_cls.cont_bits};

  // Scan state machine: one classified byte per cycle while q_pop is high.
  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    target_nxt  = target_r;
    left_nxt    = left_r;
    partial_nxt = partial_r;
    emit        = 1'b0;
    emit_point  = u8cp_pkg::ERR_POINT;
    emit_status = u8cp_pkg::ST_FOUND;

    // A start flag restarts the search before the byte is handled as a lead.
    if (q_cls.start) begin
      mode_eff   = u8cp_pkg::MODE_LEAD;
      count_eff  = '0;
      target_eff = q_index;
    end else begin
      mode_eff   = mode_r;
      count_eff  = count_r;
      target_eff = target_r;
    end

    if (q_pop) begin
      count_nxt  = count_eff;
      target_nxt = target_eff;
      if (q_cls.start) begin
        left_nxt    = '0;
        partial_nxt = '0;
      end
      unique case (mode_eff)
        u8cp_pkg::MODE_LEAD: begin
          priority if (q_cls.is_zero) begin
            emit        = 1'b1;
            emit_status = u8cp_pkg::ST_BEYOND;
          end else if (q_cls.bad_lead) begin
            emit        = 1'b1;
            emit_status = u8cp_pkg::ST_LEAD;
          end else if (count_eff == target_eff) begin
            if (q_cls.tail_len == 2'd0) begin
              emit       = 1'b1;
              emit_point = 32'(q_cls.lead_bits);
            end else begin
              partial_nxt = u8cp_pkg::POINT_W'(q_cls.lead_bits);
              left_nxt    = q_cls.tail_len;
              mode_nxt    = u8cp_pkg::MODE_TARGET;
            end
          end else if (q_cls.tail_len == 2'd0) begin
            count_nxt = count_eff + 1'b1;
            mode_nxt  = u8cp_pkg::MODE_LEAD;
          end else begin
            left_nxt = q_cls.tail_len;
            mode_nxt = u8cp_pkg::MODE_SKIP;
          end
        end
        u8cp_pkg::MODE_TARGET: begin
          if (!q_cls.is_cont) begin
            emit        = 1'b1;
            emit_status = u8cp_pkg::ST_CONT;
          end else begin
            partial_nxt = partial_new;
            left_nxt    = left_r - 1'b1;
            if (left_r == 2'd1) begin
              emit       = 1'b1;
              emit_point = 32'(partial_new);
            end
          end
        end
        u8cp_pkg::MODE_SKIP: begin
          if (q_cls.is_zero) begin
            emit        = 1'b1;
            emit_status = u8cp_pkg::ST_EARLY;
          end else begin
            left_nxt = left_r - 1'b1;
            if (left_r == 2'd1) begin
              count_nxt = count_eff + 1'b1;
              mode_nxt  = u8cp_pkg::MODE_LEAD;
            end
          end
        end
        u8cp_pkg::MODE_IDLE: begin
          mode_nxt = u8cp_pkg::MODE_IDLE;
        end
        default: begin
          mode_nxt = u8cp_pkg::MODE_IDLE;
        end
      endcase
      if (emit) begin
        mode_nxt = u8cp_pkg::MODE_IDLE;
      end
    end
  end

  // Output register: loaded by a result, cleared when its beat is taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_point_nxt  = out_point_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_point_nxt  = emit_point;
      out_status_nxt = emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= u8cp_pkg::MODE_IDLE;
      count_r     <= '0;
      target_r    <= '0;
      left_r      <= '0;
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      target_r    <= target_nxt;
      left_r      <= left_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_point_r  <= out_point_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

[rtl/utf8_code_point_at_index.sv]
// UTF-8 code point lookup by character index.
// Input channel: one string byte per beat (in_data_byte). in_string_start marks
// the first byte of a string and carries in_wanted_index, the character sought.
// Output channel: at most one beat per string, out_code_point and out_status
// (found, bad lead, bad continuation, early terminator, index beyond end);
// on any error the code point is all ones. Bytes after a result are dropped
// until the next start flag; a start flag mid-string abandons the old search.
// Throughput: one byte per cycle while out_stall holds no result. The front
// classifies each byte and writes it into a two-entry queue; the back scan
// machine retires one queued byte per cycle unless a stalled result holds it,
// and writes results into an output register. The byte that completes a
// result passes the queue and then the output register before out_valid rises.
// Reset: synchronous, active low; clears the queue, the scan state (idle,
// waiting for a start flag) and the output valid flag.
// Stall: while out_stall holds a result, the back stops; the queue fills and
// in_stall rises once it holds two bytes. The result payload stays stable.
module utf8_code_point_at_index #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_string_start,
  input  logic [31:0] in_wanted_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_code_point,
  output logic [2:0]  out_status
);

  localparam int CLS_W   = $bits(u8cp_pkg::cls_t);
  localparam int ENTRY_W = CLS_W + INDEX_WIDTH;

  logic                   q_full;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_not_empty;
  u8cp_pkg::cls_t         f_cls;
  logic [INDEX_WIDTH-1:0] f_index;
  logic [ENTRY_W-1:0]     q_wdata;
  logic [ENTRY_W-1:0]     q_rdata;
  u8cp_pkg::cls_t         b_cls;
  logic [INDEX_WIDTH-1:0] b_index;
  u8cp_pkg::status_t      b_status;

  u8cp_front #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_data_byte   (in_data_byte),
    .in_string_start(in_string_start),
    .in_wanted_index(in_wanted_index),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .q_push         (q_push),
    .q_cls          (f_cls),
    .q_index        (f_index)
  );

  assign q_wdata = {f_cls, f_index};

  u8cp_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .not_empty(q_not_empty)
  );

  assign b_cls   = u8cp_pkg::cls_t'(q_rdata[ENTRY_W-1:INDEX_WIDTH]);
  assign b_index = q_rdata[INDEX_WIDTH-1:0];

  u8cp_back #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_cls         (b_cls),
    .q_index       (b_index),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_point(out_code_point),
    .out_status    (b_status)
  );

  assign out_status = b_status;

  // The input side only stalls when the queue actually holds bytes.
  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_not_empty)
    else $error("input stalled with an empty queue");

  // The back never retires a byte while a result is held by the receiver.
  a_no_pop_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !q_pop)
    else $error("byte retired while output beat was stalled");

  // Every error status carries the all-ones code point.
  a_err_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (b_status != u8cp_pkg::ST_FOUND)) |-> (out_code_point == u8cp_pkg::ERR_POINT))
    else $error("error result without all-ones code point");

  // A found code point never exceeds 21 bits.
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (b_status == u8cp_pkg::ST_FOUND)) |-> (out_code_point[31:21] == 11'd0))
    else $error("found code point wider than 21 bits");

endmodule

[tb/tb_utf8_code_point_at_index.sv]
`timescale 1ns / 1ps

module tb_utf8_code_point_at_index;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 460;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic [31:0] index;
  } byte_beat_t;

  typedef struct {
    logic [31:0]       point;
    u8cp_pkg::status_t status;
  } lookup_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_string_start = 1'b0;
  logic [31:0] in_wanted_index = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_code_point;
  logic [2:0]  out_status;

  byte_beat_t  bytes_pending[$];
  lookup_t     lookups_due[$];
  idle_mode_t  idle_mode = IDLE_NONE;
  bit          byte_taken = 1'b0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Scan state of the lookup predictor.
  u8cp_pkg::mode_t scan_mode_p = u8cp_pkg::MODE_IDLE;
  logic [31:0]     chars_seen = 32'h0;
  logic [31:0]     target_char = 32'h0;
  logic [1:0]      tail_left = 2'd0;
  logic [20:0]     point_acc = 21'h0;

  utf8_code_point_at_index i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_string_start (in_string_start),
    .in_wanted_index (in_wanted_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_status      (out_status)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63, 0));
  endfunction

  // A lookup ends with a result; the scanner then waits for the next start.
  function automatic void post_lookup(logic [31:0] point, u8cp_pkg::status_t status);
    lookup_t res;
    res.point = point;
    res.status = status;
    lookups_due.push_back(res);
    scan_mode_p = u8cp_pkg::MODE_IDLE;
  endfunction

  // Classify a byte at a lead position and advance the character count.
  function automatic void take_lead(logic [7:0] b);
    logic [1:0]  tail;
    logic [20:0] bits;
    bit          usable;
    usable = 1'b1;
    tail = 2'd0;
    bits = 21'h0;
    if (b == 8'h00) begin
      post_lookup(u8cp_pkg::ERR_POINT, u8cp_pkg::ST_BEYOND);
      usable = 1'b0;
    end else if (b < 8'h80) begin
      bits = 21'(b);
    end else if (b < 8'hC0) begin
      post_lookup(u8cp_pkg::ERR_POINT, u8cp_pkg::ST_LEAD);
      usable = 1'b0;
    end else if (b < 8'hE0) begin
      tail = 2'd1;
      bits = 21'(b[4:0]);
    end else if (b < 8'hF0) begin
      tail = 2'd2;
      bits = 21'(b[3:0]);
    end else if (b < 8'hF8) begin
      tail = 2'd3;
      bits = 21'(b[2:0]);
    end else begin
      post_lookup(u8cp_pkg::ERR_POINT, u8cp_pkg::ST_LEAD);
      usable = 1'b0;
    end
    if (usable) begin
      if (chars_seen == target_char) begin
        if (tail == 2'd0) begin
          post_lookup(32'(bits), u8cp_pkg::ST_FOUND);
        end else begin
          point_acc = bits;
          tail_left = tail;
          scan_mode_p = u8cp_pkg::MODE_TARGET;
        end
      end else if (tail == 2'd0) begin
        chars_seen = chars_seen + 1;
        scan_mode_p = u8cp_pkg::MODE_LEAD;
      end else begin
        tail_left = tail;
        scan_mode_p = u8cp_pkg::MODE_SKIP;
      end
    end
  endfunction

  // Predict the effect of one accepted byte beat.
  function automatic void decode_byte(byte_beat_t beat);
    if (beat.first) begin
      chars_seen = 32'h0;
      target_char = beat.index;
      tail_left = 2'd0;
      point_acc = 21'h0;
      take_lead(beat.data);
    end else begin
      case (scan_mode_p)
        u8cp_pkg::MODE_LEAD: begin
          take_lead(beat.data);
        end
        u8cp_pkg::MODE_TARGET: begin
          if (beat.data < 8'h80 || beat.data > 8'hBF) begin
            post_lookup(u8cp_pkg::ERR_POINT, u8cp_pkg::ST_CONT);
          end else begin
            point_acc = {point_acc[14:0], beat.data[5:0]};
            tail_left = tail_left - 2'd1;
            if (tail_left == 2'd0) post_lookup(32'(point_acc), u8cp_pkg::ST_FOUND);
          end
        end
        u8cp_pkg::MODE_SKIP: begin
          // Tail bytes of characters ahead of the target are only checked for zero.
          if (beat.data == 8'h00) begin
            post_lookup(u8cp_pkg::ERR_POINT, u8cp_pkg::ST_EARLY);
          end else begin
            tail_left = tail_left - 2'd1;
            if (tail_left == 2'd0) begin
              chars_seen = chars_seen + 1;
              scan_mode_p = u8cp_pkg::MODE_LEAD;
            end
          end
        end
        default: begin
        end
      endcase
    end
  endfunction

  function automatic void queue_byte(logic [7:0] data, logic first, logic [31:0] index);
    byte_beat_t beat;
    beat.data = data;
    beat.first = first;
    beat.index = index;
    bytes_pending.push_back(beat);
  endfunction

  // Queue one string: mostly well formed, sometimes corrupted or cut short by
  // the next start. Returns the number of string bytes queued.
  function automatic int queue_random_string();
    logic [7:0]  text[$];
    logic [31:0] index;
    int          chars;
    int          len;
    int          k;
    chars = $urandom_range(6, 0);
    for (int i = 0; i < chars; i++) begin
      len = $urandom_range(4, 1);
      case (len)
        1: text.push_back(8'($urandom_range(127, 1)));
        2: text.push_back(8'hC0 | 8'($urandom_range(31, 0)));
        3: text.push_back(8'hE0 | 8'($urandom_range(15, 0)));
        default: text.push_back(8'hF0 | 8'($urandom_range(7, 0)));
      endcase
      for (int j = 1; j < len; j++) text.push_back(cont_byte());
    end
    text.push_back(8'h00);
    if (roll(15)) text[$urandom_range(text.size() - 1, 0)] = 8'($urandom_range(255, 0));
    if (roll(5)) begin
      k = $urandom_range(text.size() - 1, 0);
      text = text[0:k];
    end
    index = roll(10) ? $urandom : 32'($urandom_range(chars, 0));
    for (int i = 0; i < text.size(); i++) begin
      queue_byte(text[i], i == 0, (i == 0) ? index : $urandom);
    end
    // Stray bytes after a finished string are dropped by the block.
    if (roll(10)) queue_byte(8'($urandom_range(255, 0)), 1'b0, $urandom);
    return text.size();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic wait_drained();
    while (bytes_pending.size() != 0 || lookups_due.size() != 0) @(posedge clk);
  endtask

  // Sender: offer the oldest pending byte, hold it until the beat is taken.
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SEND) ? 88 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !byte_taken) begin
      in_valid <= 1'b1;
    end else if (bytes_pending.size() != 0 && !roll(idle_pct)) begin
      in_valid <= 1'b1;
      in_data_byte <= bytes_pending[0].data;
      in_string_start <= bytes_pending[0].first;
      in_wanted_index <= bytes_pending[0].index;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == IDLE_RECV) ? 88 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= roll(stall_pct);
    end
  end

  // Monitor: predict from each accepted byte, check each accepted result.
  always @(posedge clk) begin
    lookup_t due;
    byte_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_byte(bytes_pending.pop_front());
        byte_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (lookups_due.size() == 0) begin
          report_mismatch("result with none pending", out_code_point,
                          u8cp_pkg::ERR_POINT);
        end else begin
          due = lookups_due.pop_front();
          if (out_code_point !== due.point) begin
            report_mismatch("code point", out_code_point, due.point);
          end
          if (out_status !== due.status) begin
            report_mismatch("status", 32'(out_status), 32'(due.status));
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("TIMEOUT: no beat for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int sent;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings covering each status and the corner cases.
    queue_byte(8'h41, 1'b0, 32'h0);            // dropped: no string started
    queue_byte(8'h00, 1'b1, 32'h0);            // empty string
    queue_byte(8'hFF, 1'b1, 32'h0);            // invalid lead
    queue_byte(8'h7F, 1'b1, 32'h0);            // single byte found
    queue_byte(8'hC0, 1'b1, 32'h1);            // skipped tail is not inspected,
    queue_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);    // then a continuation as lead
    queue_byte(8'h80, 1'b0, 32'h0);
    queue_byte(8'hF7, 1'b1, 32'h0);            // largest four byte value
    queue_byte(8'hBF, 1'b0, 32'h0);
    queue_byte(8'hBF, 1'b0, 32'h0);
    queue_byte(8'hBF, 1'b0, 32'h0);
    queue_byte(8'hE0, 1'b1, 32'h0);            // target tail above the range
    queue_byte(8'hC0, 1'b0, 32'h0);
    queue_byte(8'h55, 1'b0, 32'h0);            // dropped after a result
    queue_byte(8'hC2, 1'b1, 32'hFFFF_FFFF);    // restart in the middle
    queue_byte(8'hE1, 1'b1, 32'h0);
    queue_byte(8'h80, 1'b0, 32'h0);
    queue_byte(8'h00, 1'b0, 32'h0);            // zero in the target tail
    queue_byte(8'h41, 1'b1, 32'h2);            // zero in a skipped tail
    queue_byte(8'hE2, 1'b0, 32'h0);
    queue_byte(8'h00, 1'b0, 32'h0);
    queue_byte(8'hC0, 1'b1, 32'h0);            // overlong form decodes as is
    queue_byte(8'h80, 1'b0, 32'h0);
    queue_byte(8'h3F, 1'b1, 32'h1);            // index past the end
    queue_byte(8'h00, 1'b0, 32'h0);
    wait_drained();

    // Random strings under each idling pattern; the sender pauses in between.
    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = idle_mode_t'(phase);
      sent = 0;
      while (sent < PHASE_BYTES) sent += queue_random_string();
      if (phase == 0) hold_requests++;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[utf8_code_point_at_index.f]
rtl/u8cp_pkg.sv
rtl/u8cp_front.sv
rtl/u8cp_queue.sv
rtl/u8cp_back.sv
rtl/utf8_code_point_at_index.sv
tb/tb_utf8_code_point_at_index.sv
